@@ rtl/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and codes for the cartridge bank controller
// Bus access and result beat structs, mapper kinds, target codes, bank state.
// ----------------------------------------------------------------------------
package cbc_pkg;

	// mapper kind from the cartridge header
	typedef enum logic [1:0] {
		MAPPER_NONE = 2'd0,
		MAPPER_MBC1 = 2'd1,
		MAPPER_MBC2 = 2'd2,
		MAPPER_MBC3 = 2'd3
	} mapper_kind_t;

	// access kind
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// result target codes
	localparam logic [1:0] TARGET_ROM  = 2'd0;
	localparam logic [1:0] TARGET_RAM  = 2'd1;
	localparam logic [1:0] TARGET_NONE = 2'd2;

	// bank register write regions, address bits 14:13 inside 0x0000-0x7fff
	localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
	localparam logic [1:0] REGION_ROM_LOW    = 2'd1;
	localparam logic [1:0] REGION_ROM_HIGH   = 2'd2;
	localparam logic [1:0] REGION_MODE       = 2'd3;

	// ram enable nibble codes
	localparam logic [3:0] NIB_ENABLE  = 4'hA;
	localparam logic [3:0] NIB_DISABLE = 4'h0;

	// reset values of the bank state
	localparam logic [7:0] ROM_BANK_RESET = 8'd1;

	typedef struct packed {
		logic        mode;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
	} cbc_in_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [21:0] mapped_address;
		logic        ram_write_allowed;
		logic [7:0]  rom_bank_now;
		logic [1:0]  ram_bank_now;
		logic        ram_enabled_now;
	} cbc_out_t;

	typedef struct packed {
		logic [7:0] rom_bank;
		logic [1:0] ram_bank;
		logic       ram_enable;
		logic       rom_banking_mode;
	} bank_state_t;

endpackage

@@ rtl/cbc_bank_regs.sv @@
// ----------------------------------------------------------------------------
// cbc_bank_regs: bank register file of the cartridge bank controller
// Holds rom/ram bank, ram enable and banking mode; applies one bus write per
// advancing beat according to the mapper kind.
// ----------------------------------------------------------------------------
module cbc_bank_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbc_pkg::mapper_kind_t mapper_kind,
	input  logic                  advance,
	input  cbc_pkg::cbc_in_t      item,
	output cbc_pkg::bank_state_t  state_cur,
	output cbc_pkg::bank_state_t  state_nxt
);
	import cbc_pkg::*;

	bank_state_t state_q;
	logic [15:0] addr;
	logic [7:0]  data;
	logic        bank_wr;

	// bank zero is remapped to bank one
	function automatic logic [7:0] nonzero_bank(input logic [7:0] b);
		return (b == 8'd0) ? 8'd1 : b;
	endfunction

	assign addr    = item.bus_address;
	assign data    = item.write_data;
	assign bank_wr = (item.mode == MODE_WRITE) && !addr[15] && (mapper_kind != MAPPER_NONE);

	// next state for a write into the bank register space
	always_comb begin
		state_nxt = state_q;
		if (bank_wr) begin
			unique case (addr[14:13])
				REGION_RAM_ENABLE: begin
					if (!(mapper_kind == MAPPER_MBC2 && addr[8])) begin
						if (data[3:0] == NIB_ENABLE)
							state_nxt.ram_enable = 1'b1;
						else if (data[3:0] == NIB_DISABLE)
							state_nxt.ram_enable = 1'b0;
					end
				end
				REGION_ROM_LOW: begin
					if (mapper_kind == MAPPER_MBC2)
						state_nxt.rom_bank = nonzero_bank({4'd0, data[3:0]});
					else if (mapper_kind == MAPPER_MBC3)
						state_nxt.rom_bank = nonzero_bank(data);
					else
						state_nxt.rom_bank = nonzero_bank({state_q.rom_bank[7:5], data[4:0]});
				end
				REGION_ROM_HIGH: begin
					if (mapper_kind == MAPPER_MBC1 && state_q.rom_banking_mode)
						state_nxt.rom_bank =
							nonzero_bank({1'b0, data[1:0], state_q.rom_bank[4:0]});
					else if (mapper_kind == MAPPER_MBC1 || mapper_kind == MAPPER_MBC3)
						state_nxt.ram_bank = data[1:0];
				end
				REGION_MODE: begin
					if (mapper_kind == MAPPER_MBC1) begin
						state_nxt.rom_banking_mode = ~data[0];
						if (!data[0])
							state_nxt.ram_bank = 2'd0;
					end
				end
				default: state_nxt = state_q;
			endcase
		end
	end

	// state register, updated once per advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank         <= ROM_BANK_RESET;
			state_q.ram_bank         <= 2'd0;
			state_q.ram_enable       <= 1'b0;
			state_q.rom_banking_mode <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign state_cur = state_q;

endmodule

@@ rtl/cbc_decode.sv @@
// ----------------------------------------------------------------------------
// cbc_decode: address translation of the cartridge bank controller
// Maps one bus access to a rom or ram byte address using the bank state held
// before the access, and reports the state after it.
// ----------------------------------------------------------------------------
module cbc_decode (
	input  cbc_pkg::cbc_in_t     item,
	input  cbc_pkg::bank_state_t state_cur,
	input  cbc_pkg::bank_state_t state_nxt,
	output cbc_pkg::cbc_out_t    result
);
	import cbc_pkg::*;

	logic [15:0] addr;

	assign addr = item.bus_address;

	// window decode and translation
	always_comb begin
		result                   = '0;
		result.target            = TARGET_NONE;
		result.mapped_address    = 22'd0;
		result.ram_write_allowed = 1'b0;
		if (addr[15:14] == 2'b00) begin
			result.target         = TARGET_ROM;
			result.mapped_address = {6'd0, addr};
		end else if (addr[15:14] == 2'b01) begin
			result.target         = TARGET_ROM;
			result.mapped_address = {state_cur.rom_bank, addr[13:0]};
		end else if (addr[15:13] == 3'b101) begin
			result.target            = TARGET_RAM;
			result.mapped_address    = {7'd0, state_cur.ram_bank, addr[12:0]};
			result.ram_write_allowed = (item.mode == MODE_WRITE) && state_cur.ram_enable;
		end
		result.rom_bank_now    = state_nxt.rom_bank;
		result.ram_bank_now    = state_nxt.ram_bank;
		result.ram_enabled_now = state_nxt.ram_enable;
	end

endmodule

@@ rtl/cartridge_bank_controller_top.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_controller_top: cartridge memory bank controller
// One bus access per beat in, one translated result per beat out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one bus access (mode, bus_address,
//   write_data). out_valid/out_stall/out_data carry one result per access:
//   target, mapped_address, ram_write_allowed and the bank state after it.
//   cfg_we/cfg_wdata write the mapper kind; write it only while idle.
//   A beat is taken at a clock edge with valid high and stall low.
// Pipeline:
//   an access lands in the input register at its accept edge and its result
//   moves into the output register when that register is free (out_valid
//   low or out_stall low). One access per cycle is sustained while out_stall
//   stays low; the bank state register is updated from combinational
//   next-state logic as each access leaves the input register.
// Reset:
//   arst_n clears both pipeline stages, sets mapper kind to none, rom bank 1,
//   ram bank 0, ram disabled and rom banking mode.
// Stall:
//   while out_stall holds a waiting result, the input register keeps its
//   access and in_stall goes high only once that register is occupied.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  cbc_pkg::cbc_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output cbc_pkg::cbc_out_t out_data
);
	import cbc_pkg::*;

	mapper_kind_t mapper_kind_q;
	logic         valid_s1;
	cbc_in_t      item_s1;
	logic         out_valid_q;
	cbc_out_t     out_data_q;
	logic         out_free;
	logic         advance;
	bank_state_t  state_cur;
	bank_state_t  state_nxt;
	cbc_out_t     result;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mapper_kind_q <= MAPPER_NONE;
		else if (cfg_we)
			mapper_kind_q <= mapper_kind_t'(cfg_wdata);
	end

	// handshake control
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	cbc_bank_regs u_bank_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.mapper_kind(mapper_kind_q),
		.advance    (advance),
		.item       (item_s1),
		.state_cur  (state_cur),
		.state_nxt  (state_nxt)
	);

	cbc_decode u_decode (
		.item     (item_s1),
		.state_cur(state_cur),
		.state_nxt(state_nxt),
		.result   (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// input side stalls only with an access held in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty input register");

	// an advancing access shows up as a result on the next cycle
	a_advance_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced access did not reach the output register");

	// rom bank never reads as zero
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_cur.rom_bank != 8'd0)
		else $error("rom bank register holds zero");

	// bank state only changes when an access advances
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_cur))
		else $error("bank state changed without an advancing access");
`endif

endmodule

@@ bench/tb_cartridge_bank_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_controller_top: bench for the cartridge bank controller
// Feeds bus access beats through the valid/stall channel, predicts every
// translated result and bank state in the bench itself, and compares each
// result beat in order. Runs a short directed list and then random phases
// over all mapper kinds with idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_controller_top;
	import cbc_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_PHASES    = 8;
	localparam int RANDOM_PER_PHASE = 90;
	localparam int MAX_PRINTED      = 40;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	cbc_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	cbc_out_t   out_data;

	// bench copy of the mapper register and bank state
	mapper_kind_t mapper;
	bank_state_t  banks;

	cbc_in_t     access_queue[$];
	cbc_out_t    expected_results[$];
	cbc_out_t    oldest;
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned accesses_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	cartridge_bank_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// bank 0 is never selectable, it reads as bank 1
	function automatic logic [7:0] nonzero_bank(logic [7:0] b);
		return (b == 8'd0) ? 8'd1 : b;
	endfunction

	// translate one access with the banks held before it, then apply its bank write
	function automatic cbc_out_t translate_access(cbc_in_t acc);
		cbc_out_t    r;
		logic [15:0] a;
		logic [7:0]  d;
		logic        wr;
		a = acc.bus_address;
		d = acc.write_data;
		wr = (acc.mode == MODE_WRITE);
		r = '0;
		r.target = TARGET_NONE;
		if (a < 16'h4000) begin
			r.target = TARGET_ROM;
			r.mapped_address = {6'd0, a};
		end else if (a < 16'h8000) begin
			r.target = TARGET_ROM;
			r.mapped_address = {banks.rom_bank, a[13:0]};
		end else if (a >= 16'hA000 && a < 16'hC000) begin
			r.target = TARGET_RAM;
			r.mapped_address = {7'd0, banks.ram_bank, a[12:0]};
			r.ram_write_allowed = wr && banks.ram_enable;
		end

		// bank register writes, ignored without a mapper
		if (wr && a < 16'h8000 && mapper != MAPPER_NONE) begin
			case (a[14:13])
				REGION_RAM_ENABLE: begin
					if (!(mapper == MAPPER_MBC2 && a[8])) begin
						if (d[3:0] == NIB_ENABLE)
							banks.ram_enable = 1'b1;
						else if (d[3:0] == NIB_DISABLE)
							banks.ram_enable = 1'b0;
					end
				end
				REGION_ROM_LOW: begin
					if (mapper == MAPPER_MBC2)
						banks.rom_bank = nonzero_bank({4'd0, d[3:0]});
					else if (mapper == MAPPER_MBC3)
						banks.rom_bank = nonzero_bank(d);
					else
						banks.rom_bank = nonzero_bank({banks.rom_bank[7:5], d[4:0]});
				end
				REGION_ROM_HIGH: begin
					if (mapper == MAPPER_MBC1 && banks.rom_banking_mode)
						banks.rom_bank = nonzero_bank({1'b0, d[1:0], banks.rom_bank[4:0]});
					else if (mapper == MAPPER_MBC1 || mapper == MAPPER_MBC3)
						banks.ram_bank = d[1:0];
				end
				REGION_MODE: begin
					if (mapper == MAPPER_MBC1) begin
						banks.rom_banking_mode = ~d[0];
						if (banks.rom_banking_mode)
							banks.ram_bank = 2'd0;
					end
				end
			endcase
		end

		r.rom_bank_now = banks.rom_bank;
		r.ram_bank_now = banks.ram_bank;
		r.ram_enabled_now = banks.ram_enable;
		return r;
	endfunction

	// random access, weighted toward bank switches and the banked windows
	function automatic cbc_in_t random_access();
		cbc_in_t     acc;
		int unsigned pick;
		pick = $urandom_range(99);
		acc.mode = 1'($urandom_range(1));
		acc.bus_address = 16'($urandom_range(16'hFFFF));
		acc.write_data = 8'($urandom_range(255));
		if (pick < 40) begin
			acc.mode = MODE_WRITE;
			acc.bus_address = 16'($urandom_range(16'h7FFF));
			if (acc.bus_address < 16'h2000 && $urandom_range(1))
				acc.write_data[3:0] = $urandom_range(1) ? NIB_ENABLE : NIB_DISABLE;
			if ($urandom_range(5) == 0)
				acc.write_data &= 8'hE0;
			if ($urandom_range(11) == 0)
				acc.write_data = 8'h00;
		end else if (pick < 65) begin
			acc.bus_address = 16'($urandom_range(16'h7FFF, 16'h4000));
			if ($urandom_range(3) != 0)
				acc.mode = MODE_READ;
		end else if (pick < 85) begin
			acc.bus_address = 16'($urandom_range(16'hBFFF, 16'hA000));
		end else if (pick < 93) begin
			acc.bus_address = $urandom_range(1) ? 16'($urandom_range(16'h9FFF, 16'h8000))
				: 16'($urandom_range(16'hFFFF, 16'hC000));
		end
		return acc;
	endfunction

	task automatic queue_access(logic m, logic [15:0] a, logic [7:0] d);
		cbc_in_t acc;
		acc.mode = m;
		acc.bus_address = a;
		acc.write_data = d;
		access_queue.insert(access_queue.size(), acc);
	endtask

	task automatic note_mismatch(string what, logic [21:0] got, logic [21:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
				what, results_checked, got, want);
	endtask

	// every access sent and every result back, then let the pipeline settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (access_queue.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mapper(mapper_kind_t kind);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= kind;
		@(posedge clk);
		cfg_we <= 1'b0;
		mapper = kind;
	endtask

	// driver: offer the next access beat, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			banks.rom_bank = ROM_BANK_RESET;
			banks.ram_bank = 2'd0;
			banks.ram_enable = 1'b0;
			banks.rom_banking_mode = 1'b1;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(), translate_access(in_data));
				accesses_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (access_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= access_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch("result with nothing pending", out_data.mapped_address, '0);
				end else begin
					oldest = expected_results.pop_front();
					if (out_data.target !== oldest.target)
						note_mismatch("target", 22'(out_data.target), 22'(oldest.target));
					if (out_data.mapped_address !== oldest.mapped_address)
						note_mismatch("mapped_address", out_data.mapped_address,
							oldest.mapped_address);
					if (out_data.ram_write_allowed !== oldest.ram_write_allowed)
						note_mismatch("ram_write_allowed", 22'(out_data.ram_write_allowed),
							22'(oldest.ram_write_allowed));
					if (out_data.rom_bank_now !== oldest.rom_bank_now)
						note_mismatch("rom_bank_now", 22'(out_data.rom_bank_now),
							22'(oldest.rom_bank_now));
					if (out_data.ram_bank_now !== oldest.ram_bank_now)
						note_mismatch("ram_bank_now", 22'(out_data.ram_bank_now),
							22'(oldest.ram_bank_now));
					if (out_data.ram_enabled_now !== oldest.ram_enabled_now)
						note_mismatch("ram_enabled_now", 22'(out_data.ram_enabled_now),
							22'(oldest.ram_enabled_now));
				end
				results_checked++;
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_cartridge_bank_controller_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int profile;
		arst_n = 1'b0;
		mapper = MAPPER_NONE;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// mbc1: window edges, disabled ram, zero bank, both banking modes
		write_mapper(MAPPER_MBC1);
		queue_access(MODE_READ, 16'h0000, 8'h00);
		queue_access(MODE_READ, 16'h3FFF, 8'hFF);
		queue_access(MODE_READ, 16'h7FFF, 8'h00);
		queue_access(MODE_READ, 16'hA000, 8'h00);
		queue_access(MODE_WRITE, 16'hBFFF, 8'hFF);
		queue_access(MODE_WRITE, 16'h0000, 8'h0A);
		queue_access(MODE_WRITE, 16'hA000, 8'h00);
		queue_access(MODE_WRITE, 16'h3FFF, 8'hE0);
		queue_access(MODE_WRITE, 16'h2000, 8'h1F);
		queue_access(MODE_WRITE, 16'h4000, 8'hFF);
		queue_access(MODE_WRITE, 16'h7FFF, 8'h01);
		queue_access(MODE_WRITE, 16'h5FFF, 8'h03);
		queue_access(MODE_READ, 16'hBFFF, 8'h00);
		queue_access(MODE_WRITE, 16'h6000, 8'h00);
		queue_access(MODE_WRITE, 16'h1FFF, 8'hF0);
		queue_access(MODE_READ, 16'hFFFF, 8'hFF);
		queue_access(MODE_WRITE, 16'h8000, 8'hFF);
		wait_idle();

		// mbc2: enable gate on address bit 8, four-bit rom bank, no ram bank
		write_mapper(MAPPER_MBC2);
		queue_access(MODE_WRITE, 16'h0100, 8'h0A);
		queue_access(MODE_WRITE, 16'h00FF, 8'h0A);
		queue_access(MODE_WRITE, 16'h2000, 8'hF0);
		queue_access(MODE_WRITE, 16'h4000, 8'h03);
		wait_idle();

		// mbc3: full eight-bit bank up to the top of rom, ram bank select
		write_mapper(MAPPER_MBC3);
		queue_access(MODE_WRITE, 16'h3FFF, 8'hFF);
		queue_access(MODE_READ, 16'h7FFF, 8'h00);
		queue_access(MODE_WRITE, 16'h4000, 8'hFF);
		queue_access(MODE_WRITE, 16'h2000, 8'h00);
		wait_idle();

		// random phases over every mapper kind and idle pattern
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_mapper(mapper_kind_t'(p % 4));
			profile = (p + p / 4) % 4;
			sender_idle_pct = (profile == 1) ? 59 : (profile == 3) ? 18 : 0;
			receiver_stall_pct = (profile == 2) ? 59 : (profile == 3) ? 18 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				access_queue.insert(access_queue.size(), random_access());
			wait_idle();
		end

		$display("ran %0d accesses: directed edges, then %0d random phases over all mapper kinds",
			accesses_sent, RANDOM_PHASES);
		$display("with sender gaps and receiver stalls; %0d results compared, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("tb_cartridge_bank_controller_top OK");
		else
			$display("tb_cartridge_bank_controller_top NOT OK");
		$finish;
	end

endmodule
